// ===== rtl/inode_block_bitmap_allocator_assert.svh =====
// Assertion macros for the inode and block bitmap allocator
`ifndef INODE_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define INODE_BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define IBBA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IBBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ibba_pkg.sv =====
// Package for the inode and block bitmap allocator: constants, types and microcode
`default_nettype none
package ibba_pkg;

    localparam int BLOCK_COUNT_DEF        = 1024;
    localparam int SLOTS_PER_TABLE_DEF    = 32;
    localparam int POINTERS_PER_INODE_DEF = 6;
    localparam int RESERVED_BLOCKS_DEF    = 5;
    localparam int TABLE_BLOCKS_DEF       = 4;

    localparam int MAP_WORD_W = 32;
    localparam int MAP_BIT_W  = $clog2(MAP_WORD_W);

    localparam int STATUS_W   = 2;
    localparam int INO_OUT_W  = 7;
    localparam int CNT_OUT_W  = 10;
    localparam int TB_W       = 3;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;

    localparam logic [CNT_OUT_W-1:0] INODES_FREE_AT_FORMAT = 10'd1022;
    localparam logic [CNT_OUT_W-1:0] CNT_MAX               = 10'h3FF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SLOT   = 2'd1,
        ST_NO_BLOCKS = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_FIND_SLOT,
        OP_SCAN_INIT,
        OP_LOAD_WORD,
        OP_PICK,
        OP_NEXT_WORD,
        OP_COMMIT,
        OP_RD_PICK,
        OP_WR_PICK,
        OP_CLR_IDX,
        OP_EMIT_PICK,
        OP_FORMAT,
        OP_EMIT_ONE
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_FORMAT,
        C_NO_SLOT,
        C_COUNT_FULL,
        C_WORD_FREE,
        C_LAST_WORD,
        C_MORE_PICKS
    } cond_t;

    localparam int PC_W = 5;

    localparam logic [PC_W-1:0] STEP_WAIT     = 5'd0;
    localparam logic [PC_W-1:0] STEP_DISPATCH = 5'd1;
    localparam logic [PC_W-1:0] STEP_FIND     = 5'd2;
    localparam logic [PC_W-1:0] STEP_SLOT_CHK = 5'd3;
    localparam logic [PC_W-1:0] STEP_SCAN     = 5'd4;
    localparam logic [PC_W-1:0] STEP_LOAD0    = 5'd5;
    localparam logic [PC_W-1:0] STEP_FULL_CHK = 5'd6;
    localparam logic [PC_W-1:0] STEP_PICK     = 5'd7;
    localparam logic [PC_W-1:0] STEP_NEXT     = 5'd8;
    localparam logic [PC_W-1:0] STEP_LOAD     = 5'd9;
    localparam logic [PC_W-1:0] STEP_COMMIT   = 5'd10;
    localparam logic [PC_W-1:0] STEP_RD       = 5'd11;
    localparam logic [PC_W-1:0] STEP_WR       = 5'd12;
    localparam logic [PC_W-1:0] STEP_REWIND   = 5'd13;
    localparam logic [PC_W-1:0] STEP_EMIT     = 5'd14;
    localparam logic [PC_W-1:0] STEP_DONE     = 5'd15;
    localparam logic [PC_W-1:0] STEP_FORMAT   = 5'd16;
    localparam logic [PC_W-1:0] STEP_FMT_OUT  = 5'd17;
    localparam logic [PC_W-1:0] STEP_ERR_SLOT = 5'd18;
    localparam logic [PC_W-1:0] STEP_ERR_BLK  = 5'd19;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic             wait_out;
        status_t          status;
        logic [PC_W-1:0]  target;
    } cw_t;

    typedef struct packed {
        logic no_accept;
        logic format;
        logic no_slot;
        logic count_full;
        logic word_free;
        logic last_word;
        logic more_picks;
        logic out_busy;
    } flags_t;

    function automatic cw_t mk(input op_t op, input cond_t cond, input logic [PC_W-1:0] target);
        cw_t w;
        w.op       = op;
        w.cond     = cond;
        w.wait_out = 1'b0;
        w.status   = ST_OK;
        w.target   = target;
        return w;
    endfunction

    function automatic cw_t mk_out(input op_t op, input cond_t cond, input status_t st,
                                   input logic [PC_W-1:0] target);
        cw_t w;
        w          = mk(op, cond, target);
        w.wait_out = 1'b1;
        w.status   = st;
        return w;
    endfunction

    // control store
    function automatic cw_t ucode(input logic [PC_W-1:0] pc);
        cw_t w;
        case (pc)
            STEP_WAIT:     w = mk(OP_ACCEPT, C_NO_ACCEPT, STEP_WAIT);
            STEP_DISPATCH: w = mk(OP_NOP, C_FORMAT, STEP_FORMAT);
            STEP_FIND:     w = mk(OP_FIND_SLOT, C_NEVER, STEP_WAIT);
            STEP_SLOT_CHK: w = mk(OP_NOP, C_NO_SLOT, STEP_ERR_SLOT);
            STEP_SCAN:     w = mk(OP_SCAN_INIT, C_NEVER, STEP_WAIT);
            STEP_LOAD0:    w = mk(OP_LOAD_WORD, C_NEVER, STEP_WAIT);
            STEP_FULL_CHK: w = mk(OP_NOP, C_COUNT_FULL, STEP_COMMIT);
            STEP_PICK:     w = mk(OP_PICK, C_WORD_FREE, STEP_FULL_CHK);
            STEP_NEXT:     w = mk(OP_NEXT_WORD, C_LAST_WORD, STEP_ERR_BLK);
            STEP_LOAD:     w = mk(OP_LOAD_WORD, C_ALWAYS, STEP_FULL_CHK);
            STEP_COMMIT:   w = mk(OP_COMMIT, C_NEVER, STEP_WAIT);
            STEP_RD:       w = mk(OP_RD_PICK, C_NEVER, STEP_WAIT);
            STEP_WR:       w = mk(OP_WR_PICK, C_MORE_PICKS, STEP_RD);
            STEP_REWIND:   w = mk(OP_CLR_IDX, C_NEVER, STEP_WAIT);
            STEP_EMIT:     w = mk_out(OP_EMIT_PICK, C_MORE_PICKS, ST_OK, STEP_EMIT);
            STEP_DONE:     w = mk(OP_NOP, C_ALWAYS, STEP_WAIT);
            STEP_FORMAT:   w = mk(OP_FORMAT, C_NEVER, STEP_WAIT);
            STEP_FMT_OUT:  w = mk_out(OP_EMIT_ONE, C_ALWAYS, ST_OK, STEP_WAIT);
            STEP_ERR_SLOT: w = mk_out(OP_EMIT_ONE, C_ALWAYS, ST_NO_SLOT, STEP_WAIT);
            STEP_ERR_BLK:  w = mk_out(OP_EMIT_ONE, C_ALWAYS, ST_NO_BLOCKS, STEP_WAIT);
            default:       w = mk(OP_NOP, C_ALWAYS, STEP_WAIT);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/inode_block_bitmap_allocator.sv =====
// Top level of the inode and block bitmap allocator: datapath, maps and stream ports
//
//  channel | dir | tdata (low bit up)                               | tuser  | tlast
//  s_      | in  | table_block[2:0], is_folder[3], pad             | kind   | -
//  m_      | out | inode_number, block_number, free_blocks,         | status | last
//          |     | free_inodes, folder_count, pad                   |        |
//
// Format: accept, dispatch, clear, result. Allocation: slot search, bitmap word scan
// with picks, commit, a read-modify-write of the block map RAM per pointer, then one
// result per pointer. The scan reads the block map RAM one bitmap word at a time.
// Reset clears the row valid bits of the block map and the inode map; no clearing pass.
// A stalled result holds the sequencer on its output step.
`default_nettype none
module inode_block_bitmap_allocator import ibba_pkg::*; #(
    parameter int BLOCK_COUNT        = BLOCK_COUNT_DEF,
    parameter int SLOTS_PER_TABLE    = SLOTS_PER_TABLE_DEF,
    parameter int POINTERS_PER_INODE = POINTERS_PER_INODE_DEF,
    parameter int RESERVED_BLOCKS    = RESERVED_BLOCKS_DEF,
    parameter int TABLE_BLOCKS       = TABLE_BLOCKS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // table_block[2:0], is_folder[3]
    input  wire logic                 s_tuser,   // kind
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // inode_number[6:0], block_number[16:7],
                                                 // free_blocks[26:17], free_inodes[36:27],
                                                 // folder_count[46:37]
    output logic      [STATUS_W-1:0]  m_tuser,   // status
    output logic                      m_tlast
);

    `include "inode_block_bitmap_allocator_assert.svh"

    localparam int WORDS  = (BLOCK_COUNT + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BLK_W  = WA_W + MAP_BIT_W;
    localparam int SLOT_W = $clog2(SLOTS_PER_TABLE);
    localparam int ROW_W  = (TABLE_BLOCKS > 1) ? $clog2(TABLE_BLOCKS) : 1;
    localparam int INO_W  = $clog2(TABLE_BLOCKS * SLOTS_PER_TABLE);
    localparam int IDX_W  = (POINTERS_PER_INODE > 1) ? $clog2(POINTERS_PER_INODE) : 1;
    localparam int CNT_W  = $clog2(POINTERS_PER_INODE + 1);

    cw_t    cw;
    logic   go;
    flags_t flags;

    ibba_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .cw      (cw),
        .go      (go)
    );

    // control state
    logic [SLOTS_PER_TABLE-1:0] inode_map_reg [TABLE_BLOCKS];
    logic [SLOTS_PER_TABLE-1:0] inode_map_next [TABLE_BLOCKS];
    logic [WORDS-1:0]           row_valid_reg, row_valid_next;
    logic [CNT_OUT_W-1:0]       fb_reg, fb_next, fi_reg, fi_next, fc_reg, fc_next;
    logic                       m_tvalid_reg, m_tvalid_next;

    // working registers
    logic                       kind_reg, kind_next, folder_reg, folder_next;
    logic [TB_W-1:0]            tb_reg, tb_next;
    logic [ROW_W-1:0]           ino_row_reg, ino_row_next;
    logic [SLOT_W-1:0]          ino_slot_reg, ino_slot_next;
    logic [INO_W-1:0]           ino_reg, ino_next;
    logic                       slot_ok_reg, slot_ok_next;
    logic [WA_W-1:0]            widx_reg, widx_next;
    logic [MAP_WORD_W-1:0]      word_reg, word_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [IDX_W-1:0]           pidx_reg, pidx_next;
    logic [BLK_W-1:0]           pick_reg [POINTERS_PER_INODE];
    logic [BLK_W-1:0]           pick_next [POINTERS_PER_INODE];
    logic                       m_tlast_reg, m_tlast_next;
    status_t                    m_status_reg, m_status_next;
    logic [INO_OUT_W-1:0]       m_ino_reg, m_ino_next;
    logic [CNT_OUT_W-1:0]       m_blk_reg, m_blk_next;
    logic [CNT_OUT_W-1:0]       m_fb_reg, m_fb_next, m_fi_reg, m_fi_next, m_fc_reg, m_fc_next;

    // datapath nets
    logic                       tb_ok;
    logic [ROW_W-1:0]           row_idx;
    logic [SLOTS_PER_TABLE-1:0] row_bits;
    logic [SLOT_W-1:0]          free_slot;
    logic                       slot_found;
    logic [MAP_WORD_W-1:0]      edge_mask, word_in;
    logic [MAP_BIT_W-1:0]       word_bit;
    logic                       word_free;
    logic [BLK_W-1:0]           pick_cur, pick_val;
    logic [WA_W-1:0]            pick_word;
    logic [MAP_BIT_W-1:0]       pick_bit;
    logic                       pick_we;
    logic                       ram_we;
    logic [WA_W-1:0]            ram_raddr;
    logic [MAP_WORD_W-1:0]      ram_wdata, ram_rdata;

    ibba_ram #(
        .WIDTH (MAP_WORD_W),
        .DEPTH (WORDS)
    ) u_block_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pick_word),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // inode slot search; slots 0 and 1 of table 1 hold the root inodes
    always_comb begin
        tb_ok    = (tb_reg != '0) && ({1'b0, tb_reg} <= 4'(TABLE_BLOCKS));
        row_idx  = ROW_W'(tb_reg - 3'd1);
        row_bits = inode_map_reg[row_idx]
                 | ((tb_reg == 3'd1) ? SLOTS_PER_TABLE'(2'b11) : '0);
        free_slot  = '0;
        slot_found = 1'b0;
        for (int i = SLOTS_PER_TABLE - 1; i >= 0; i--) begin
            if (!row_bits[i]) begin
                free_slot  = SLOT_W'(i);
                slot_found = 1'b1;
            end
        end
    end

    // block map word: reserved blocks and blocks past the end read as used
    always_comb begin
        for (int b = 0; b < MAP_WORD_W; b++) begin
            edge_mask[b] = (32'({widx_reg, MAP_BIT_W'(b)}) < RESERVED_BLOCKS)
                        || (32'({widx_reg, MAP_BIT_W'(b)}) >= BLOCK_COUNT);
        end
        word_in  = (row_valid_reg[widx_reg] ? ram_rdata : '0) | edge_mask;
        word_bit = '0;
        for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
            if (!word_reg[i]) begin
                word_bit = MAP_BIT_W'(i);
            end
        end
        word_free = (word_reg != '1);
    end

    assign pick_cur  = pick_reg[pidx_reg];
    assign pick_word = pick_cur[BLK_W-1:MAP_BIT_W];
    assign pick_bit  = pick_cur[MAP_BIT_W-1:0];
    assign pick_val  = {widx_reg, word_bit};
    assign pick_we   = go && (cw.op == OP_PICK) && word_free;
    assign ram_wdata = (row_valid_reg[pick_word] ? ram_rdata : '0)
                     | (MAP_WORD_W'(1) << pick_bit);

    always_comb begin
        flags.no_accept  = !s_tvalid;
        flags.format     = !kind_reg;
        flags.no_slot    = !slot_ok_reg;
        flags.count_full = (cnt_reg == CNT_W'(POINTERS_PER_INODE));
        flags.word_free  = word_free;
        flags.last_word  = (widx_reg == WA_W'(WORDS - 1));
        flags.more_picks = (pidx_reg != IDX_W'(POINTERS_PER_INODE - 1));
        flags.out_busy   = m_tvalid_reg && !m_tready;
    end

    assign s_tready = (cw.op == OP_ACCEPT);

    always_comb begin
        inode_map_next = inode_map_reg;
        row_valid_next = row_valid_reg;
        fb_next        = fb_reg;
        fi_next        = fi_reg;
        fc_next        = fc_reg;
        kind_next      = kind_reg;
        folder_next    = folder_reg;
        tb_next        = tb_reg;
        ino_row_next   = ino_row_reg;
        ino_slot_next  = ino_slot_reg;
        ino_next       = ino_reg;
        slot_ok_next   = slot_ok_reg;
        widx_next      = widx_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        pidx_next      = pidx_reg;
        pick_next      = pick_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tlast_next   = m_tlast_reg;
        m_status_next  = m_status_reg;
        m_ino_next     = m_ino_reg;
        m_blk_next     = m_blk_reg;
        m_fb_next      = m_fb_reg;
        m_fi_next      = m_fi_reg;
        m_fc_next      = m_fc_reg;
        ram_we         = 1'b0;
        ram_raddr      = widx_reg;

        if (go) begin
            case (cw.op)
                OP_ACCEPT: begin
                    if (s_tvalid) begin
                        kind_next   = s_tuser;
                        tb_next     = s_tdata[TB_W-1:0];
                        folder_next = s_tdata[TB_W];
                    end
                end
                OP_FIND_SLOT: begin
                    ino_row_next  = row_idx;
                    ino_slot_next = free_slot;
                    ino_next      = INO_W'(INO_W'(row_idx) * INO_W'(SLOTS_PER_TABLE)
                                         + INO_W'(free_slot));
                    slot_ok_next  = tb_ok && slot_found;
                end
                OP_SCAN_INIT: begin
                    widx_next = '0;
                    cnt_next  = '0;
                    ram_raddr = '0;
                end
                OP_LOAD_WORD: begin
                    word_next = word_in;
                end
                OP_PICK: begin
                    if (word_free) begin
                        pick_next[cnt_reg[IDX_W-1:0]] = pick_val;
                        word_next = word_reg | (MAP_WORD_W'(1) << word_bit);
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
                OP_NEXT_WORD: begin
                    widx_next = widx_reg + 1'b1;
                    ram_raddr = widx_reg + 1'b1;
                end
                OP_COMMIT: begin
                    inode_map_next[ino_row_reg][ino_slot_reg] = 1'b1;
                    fb_next = (fb_reg >= CNT_OUT_W'(POINTERS_PER_INODE))
                            ? fb_reg - CNT_OUT_W'(POINTERS_PER_INODE) : '0;
                    if (fi_reg != '0) begin
                        fi_next = fi_reg - 1'b1;
                    end
                    if (folder_reg && (fc_reg != CNT_MAX)) begin
                        fc_next = fc_reg + 1'b1;
                    end
                    pidx_next = '0;
                end
                OP_RD_PICK: begin
                    ram_raddr = pick_word;
                end
                OP_WR_PICK: begin
                    ram_we                    = 1'b1;
                    row_valid_next[pick_word] = 1'b1;
                    pidx_next                 = pidx_reg + 1'b1;
                end
                OP_CLR_IDX: begin
                    pidx_next = '0;
                end
                OP_EMIT_PICK: begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = !flags.more_picks;
                    m_status_next = ST_OK;
                    m_ino_next    = INO_OUT_W'(ino_reg);
                    m_blk_next    = CNT_OUT_W'(pick_cur);
                    m_fb_next     = fb_reg;
                    m_fi_next     = fi_reg;
                    m_fc_next     = fc_reg;
                    pidx_next     = pidx_reg + 1'b1;
                end
                OP_FORMAT: begin
                    for (int t = 0; t < TABLE_BLOCKS; t++) begin
                        inode_map_next[t] = '0;
                    end
                    row_valid_next = '0;
                    fb_next        = CNT_OUT_W'(BLOCK_COUNT - RESERVED_BLOCKS);
                    fi_next        = INODES_FREE_AT_FORMAT;
                    fc_next        = '0;
                end
                OP_EMIT_ONE: begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    m_status_next = cw.status;
                    m_ino_next    = '0;
                    m_blk_next    = '0;
                    m_fb_next     = fb_reg;
                    m_fi_next     = fi_reg;
                    m_fc_next     = fc_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < TABLE_BLOCKS; t++) begin
                inode_map_reg[t] <= '0;
            end
            row_valid_reg <= '0;
            fb_reg        <= '0;
            fi_reg        <= '0;
            fc_reg        <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            inode_map_reg <= inode_map_next;
            row_valid_reg <= row_valid_next;
            fb_reg        <= fb_next;
            fi_reg        <= fi_next;
            fc_reg        <= fc_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        folder_reg   <= folder_next;
        tb_reg       <= tb_next;
        ino_row_reg  <= ino_row_next;
        ino_slot_reg <= ino_slot_next;
        ino_reg      <= ino_next;
        slot_ok_reg  <= slot_ok_next;
        widx_reg     <= widx_next;
        word_reg     <= word_next;
        cnt_reg      <= cnt_next;
        pidx_reg     <= pidx_next;
        pick_reg     <= pick_next;
        m_tlast_reg  <= m_tlast_next;
        m_status_reg <= m_status_next;
        m_ino_reg    <= m_ino_next;
        m_blk_reg    <= m_blk_next;
        m_fb_reg     <= m_fb_next;
        m_fi_reg     <= m_fi_next;
        m_fc_reg     <= m_fc_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {1'b0, m_fc_reg, m_fi_reg, m_fb_reg, m_blk_reg, m_ino_reg};

    `IBBA_ASSERT_SAME(a_commit_full, cw.op == OP_COMMIT,
        cnt_reg == CNT_W'(POINTERS_PER_INODE), "commit without a full set of blocks")
    `IBBA_ASSERT_SAME(a_pick_range, pick_we,
        (32'(pick_val) >= RESERVED_BLOCKS) && (32'(pick_val) < BLOCK_COUNT),
        "picked block outside the data area")
    `IBBA_ASSERT_SAME(a_err_last, m_tvalid && (m_tuser != ST_OK), m_tlast,
        "error word not marked last")
    `IBBA_ASSERT_NEXT(a_one_accept, s_tvalid && s_tready, !s_tready,
        "input taken twice in a row")

endmodule
`default_nettype wire

// ===== rtl/ibba_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module ibba_ram import ibba_pkg::*; #(
    parameter int WIDTH = MAP_WORD_W,
    parameter int DEPTH = BLOCK_COUNT_DEF / MAP_WORD_W,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/ibba_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps
`default_nettype none
module ibba_seq import ibba_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire flags_t flags,
    output cw_t         cw,
    output logic        go
);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            take;

    assign cw = ucode(pc_reg);

    always_comb begin
        go = !(cw.wait_out && flags.out_busy);
        unique case (cw.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_ACCEPT:  take = flags.no_accept;
            C_FORMAT:     take = flags.format;
            C_NO_SLOT:    take = flags.no_slot;
            C_COUNT_FULL: take = flags.count_full;
            C_WORD_FREE:  take = flags.word_free;
            C_LAST_WORD:  take = flags.last_word;
            C_MORE_PICKS: take = flags.more_picks;
            default:      take = 1'b0;
        endcase
        if (!go) begin
            pc_next = pc_reg;
        end else if (take) begin
            pc_next = cw.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

// ===== tb/inode_block_bitmap_allocator_test.sv =====
// Self-checking testbench for the inode and block bitmap allocator
`timescale 1ns / 1ps
`default_nettype none
module inode_block_bitmap_allocator_test;
    import ibba_pkg::*;

    localparam logic KIND_FORMAT = 1'b0;
    localparam logic KIND_ALLOC  = 1'b1;
    localparam int   RANDOM_ITEMS = 415;
    localparam int   CYCLE_LIMIT  = 500000;
    localparam int   DRAIN_CYCLES = 200;
    localparam int   NUM_DIRECTED = 15;

    localparam int   STALL_OPEN   = 0;
    localparam int   STALL_COIN   = 1;
    localparam int   STALL_QUART  = 2;

    typedef struct packed {
        status_t                status;
        logic [INO_OUT_W-1:0]   ino;
        logic [CNT_OUT_W-1:0]   blk;
        logic [CNT_OUT_W-1:0]   free_blk;
        logic [CNT_OUT_W-1:0]   free_ino;
        logic [CNT_OUT_W-1:0]   folders;
        logic                   last;
    } alloc_word_t;

    typedef struct packed {
        logic           kind;
        logic [TB_W-1:0] tb;
        logic           folder;
        bit             typed;
        alloc_word_t    word;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;

    inode_block_bitmap_allocator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // shadow of the allocator state
    bit                   blk_used [BLOCK_COUNT_DEF];
    bit                   ino_used [1024];
    logic [CNT_OUT_W-1:0] free_blk_cnt = '0;
    logic [CNT_OUT_W-1:0] free_ino_cnt = '0;
    logic [CNT_OUT_W-1:0] folder_cnt   = '0;

    alloc_word_t pending_words[$];
    stim_row_t   directed_rows [NUM_DIRECTED];
    int          err_count  = 0;
    int          cycles     = 0;
    int          burst_left = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic alloc_word_t make_word(input status_t st, input int ino, input int blk,
                                              input logic last);
        alloc_word_t w;
        w.status   = st;
        w.ino      = INO_OUT_W'(ino);
        w.blk      = CNT_OUT_W'(blk);
        w.free_blk = free_blk_cnt;
        w.free_ino = free_ino_cnt;
        w.folders  = folder_cnt;
        w.last     = last;
        return w;
    endfunction

    function automatic void predict_alloc_words(input logic kind, input logic [TB_W-1:0] tb,
                                                input logic folder, ref alloc_word_t words[$]);
        int tbi;
        int ino;
        int n;
        int picked [POINTERS_PER_INODE_DEF];
        bit found;
        words.delete();
        tbi = int'(tb);
        if (kind == KIND_FORMAT) begin
            foreach (blk_used[i]) blk_used[i] = (i < RESERVED_BLOCKS_DEF);
            foreach (ino_used[i]) ino_used[i] = (i < 2);
            free_blk_cnt = CNT_OUT_W'(BLOCK_COUNT_DEF - RESERVED_BLOCKS_DEF);
            free_ino_cnt = INODES_FREE_AT_FORMAT;
            folder_cnt   = '0;
            words.push_back(make_word(ST_OK, 0, 0, 1'b1));
            return;
        end
        if (tbi < 1 || tbi > TABLE_BLOCKS_DEF) begin
            words.push_back(make_word(ST_NO_SLOT, 0, 0, 1'b1));
            return;
        end
        // first free slot; slots 0 and 1 of table 1 are reserved
        found = 1'b0;
        ino   = 0;
        for (int s = (tbi == 1) ? 2 : 0; s < SLOTS_PER_TABLE_DEF && !found; s++) begin
            if (!ino_used[(tbi - 1) * SLOTS_PER_TABLE_DEF + s]) begin
                ino   = (tbi - 1) * SLOTS_PER_TABLE_DEF + s;
                found = 1'b1;
            end
        end
        if (!found) begin
            words.push_back(make_word(ST_NO_SLOT, 0, 0, 1'b1));
            return;
        end
        n = 0;
        for (int b = RESERVED_BLOCKS_DEF; b < BLOCK_COUNT_DEF && n < POINTERS_PER_INODE_DEF;
             b++) begin
            if (!blk_used[b]) begin
                picked[n] = b;
                n++;
            end
        end
        if (n < POINTERS_PER_INODE_DEF) begin
            words.push_back(make_word(ST_NO_BLOCKS, 0, 0, 1'b1));
            return;
        end
        foreach (picked[i]) blk_used[picked[i]] = 1'b1;
        ino_used[ino] = 1'b1;
        free_blk_cnt = (free_blk_cnt >= POINTERS_PER_INODE_DEF) ?
                       free_blk_cnt - CNT_OUT_W'(POINTERS_PER_INODE_DEF) : '0;
        if (free_ino_cnt != 0)
            free_ino_cnt = free_ino_cnt - 1'b1;
        if (folder && folder_cnt != CNT_MAX)
            folder_cnt = folder_cnt + 1'b1;
        foreach (picked[i])
            words.push_back(make_word(ST_OK, ino, picked[i], i == POINTERS_PER_INODE_DEF - 1));
    endfunction

    function automatic stim_row_t row(input logic kind, input int tb, input logic folder);
        stim_row_t r;
        r.kind   = kind;
        r.tb     = TB_W'(tb);
        r.folder = folder;
        r.typed  = 1'b0;
        r.word   = '0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic kind, input int tb, input logic folder,
                                            input status_t st, input int fb, input int fi,
                                            input int fc);
        stim_row_t r;
        r               = row(kind, tb, folder);
        r.typed         = 1'b1;
        r.word.status   = st;
        r.word.free_blk = CNT_OUT_W'(fb);
        r.word.free_ino = CNT_OUT_W'(fi);
        r.word.folders  = CNT_OUT_W'(fc);
        r.word.last     = 1'b1;
        return r;
    endfunction

    task automatic send_item(input stim_row_t r);
        alloc_word_t words[$];
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, r.folder, r.tb};
        s_tuser  <= r.kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_alloc_words(r.kind, r.tb, r.folder, words);
        if (r.typed)
            pending_words.push_back(r.word);
        else
            foreach (words[i]) pending_words.push_back(words[i]);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    // result monitor
    always @(posedge aclk) begin
        alloc_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got tdata %h status %0d",
                         $time, m_tdata, m_tuser);
                err_count++;
            end else begin
                w = pending_words.pop_front();
                check_field("status",       int'(w.status),   int'(m_tuser));
                check_field("inode_number", int'(w.ino),      int'(m_tdata[6:0]));
                check_field("block_number", int'(w.blk),      int'(m_tdata[16:7]));
                check_field("free_blocks",  int'(w.free_blk), int'(m_tdata[26:17]));
                check_field("free_inodes",  int'(w.free_ino), int'(m_tdata[36:27]));
                check_field("folder_count", int'(w.folders),  int'(m_tdata[46:37]));
                check_field("last",         int'(w.last),     int'(m_tlast));
            end
        end
    end

    // receiver back-pressure: mode changes every stretch of cycles
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            STALL_OPEN:  m_tready <= 1'b1;
            STALL_COIN:  m_tready <= 1'($urandom_range(0, 1));
            STALL_QUART: m_tready <= (stall_tick % 4 == 0);
            default:     m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        stim_row_t r;
        int        sent;
        int        focus;
        int        phase_len;
        int        pick;

        // allocation before format, out-of-range tables, allocations in every table, then a reformat
        directed_rows = '{
            row(KIND_ALLOC, 1, 1'b1),
            typed_row(KIND_ALLOC, 0, 1'b0, ST_NO_SLOT, 0, 0, 1),
            typed_row(KIND_FORMAT, 7, 1'b1, ST_OK, 1019, 1022, 0),
            typed_row(KIND_ALLOC, 0, 1'b0, ST_NO_SLOT, 1019, 1022, 0),
            typed_row(KIND_ALLOC, 5, 1'b1, ST_NO_SLOT, 1019, 1022, 0),
            typed_row(KIND_ALLOC, 6, 1'b0, ST_NO_SLOT, 1019, 1022, 0),
            typed_row(KIND_ALLOC, 7, 1'b1, ST_NO_SLOT, 1019, 1022, 0),
            row(KIND_ALLOC, 1, 1'b0),
            row(KIND_ALLOC, 1, 1'b1),
            row(KIND_ALLOC, 2, 1'b1),
            row(KIND_ALLOC, 3, 1'b0),
            row(KIND_ALLOC, 4, 1'b1),
            row(KIND_ALLOC, 4, 1'b0),
            typed_row(KIND_FORMAT, 0, 1'b0, ST_OK, 1019, 1022, 0),
            row(KIND_ALLOC, 4, 1'b1)
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) send_item(directed_rows[i]);

        // phases: format, then mostly allocations leaning on one table so it fills up
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            send_item(row(KIND_FORMAT, $urandom_range(0, 7), 1'($urandom_range(0, 1))));
            sent++;
            focus     = $urandom_range(1, 4);
            phase_len = $urandom_range(30, 150);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    r = row(KIND_FORMAT, $urandom_range(0, 7), 1'($urandom_range(0, 1)));
                else if (pick < 12)
                    r = row(KIND_ALLOC, $urandom_range(0, 7), 1'($urandom_range(0, 1)));
                else if (pick < 60)
                    r = row(KIND_ALLOC, focus, 1'($urandom_range(0, 1)));
                else
                    r = row(KIND_ALLOC, $urandom_range(1, 4), 1'($urandom_range(0, 1)));
                send_item(r);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
